// File: design/gbs_pkg.sv
// Shared types, constants and helpers for the greedy box suppression block.
// No dependencies; every other file of the block but gbs_ram imports this package.
`timescale 1ns / 1ps

package gbs_pkg;

  localparam int COORD_W          = 12;
  localparam int AREA_W           = 2 * COORD_W;
  localparam int UNION_W          = AREA_W + 1;
  localparam int THR_W            = 9;
  localparam int TOTAL_W          = 7;
  localparam int MAX_ACCEPTED_DEF = 64;
  localparam logic [THR_W-1:0] THR_RESET = 9'd128;

  // One box in exclusive form: [left, left+width) by [top, top+height)
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // Queued candidate with its own area worked out at intake
  typedef struct packed {
    logic               first_of_set;
    box_t               box;
    logic [AREA_W-1:0]  area;
  } item_t;

  // Overlap unit status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic hit;
  } iou_status_t;

  // Length of the overlap of two spans, zero when they do not meet
  function automatic logic [COORD_W-1:0] span_overlap(
    input logic [COORD_W-1:0] a0,
    input logic [COORD_W-1:0] alen,
    input logic [COORD_W-1:0] b0,
    input logic [COORD_W-1:0] blen
  );
    logic [COORD_W:0] lo;
    logic [COORD_W:0] ae;
    logic [COORD_W:0] be;
    logic [COORD_W:0] hi;
    logic [COORD_W:0] diff;
    lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae   = {1'b0, a0} + {1'b0, alen};
    be   = {1'b0, b0} + {1'b0, blen};
    hi   = (ae < be) ? ae : be;
    diff = hi - lo;
    return (hi > lo) ? diff[COORD_W-1:0] : '0;
  endfunction

endpackage

// File: design/gbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/gbs_front.sv
// Intake side: takes candidate boxes, works out their area and holds them
// in a two-entry queue for the back end. Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        first_of_set,
  input  logic [gbs_pkg::COORD_W-1:0] box_left,
  input  logic [gbs_pkg::COORD_W-1:0] box_top,
  input  logic [gbs_pkg::COORD_W-1:0] box_width,
  input  logic [gbs_pkg::COORD_W-1:0] box_height,
  output logic                        q_valid,
  input  logic                        q_pop,
  output gbs_pkg::item_t              q_item
);
  import gbs_pkg::*;

  item_t       entries [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  fill;
  item_t       item_in;
  logic        push;

  // Build the queue item and work out the area of the incoming box
  always_comb begin
    item_in.first_of_set = first_of_set;
    item_in.box.left     = box_left;
    item_in.box.top      = box_top;
    item_in.box.width    = box_width;
    item_in.box.height   = box_height;
    item_in.area         = AREA_W'(box_width) * AREA_W'(box_height);
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entries[rptr];

  // Store a transfer into the queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= item_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: design/gbs_iou.sv
// Pipelined overlap test of one stored box against the candidate per cycle:
// intersection*256 >= threshold*union marks a hit. Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_iou (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_issue,
  input  gbs_pkg::box_t              stored,
  input  gbs_pkg::box_t              cand,
  input  logic [gbs_pkg::AREA_W-1:0] cand_area,
  input  logic [gbs_pkg::THR_W-1:0]  thr,
  output gbs_pkg::iou_status_t       status
);
  import gbs_pkg::*;

  localparam int PROD_W = THR_W + UNION_W;

  logic v0, v1, v2, v3, v4;

  logic [COORD_W-1:0] ow1, oh1;
  logic [AREA_W-1:0]  area_s1;
  logic [AREA_W-1:0]  inter2, area_s2;
  logic [AREA_W-1:0]  inter3;
  logic [UNION_W-1:0] uni3;
  logic               hit4;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  inter_sh;

  // Track valid work through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= rd_issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: span overlaps and stored area
  always_ff @(posedge clk) begin
    ow1     <= span_overlap(stored.left, stored.width, cand.left, cand.width);
    oh1     <= span_overlap(stored.top, stored.height, cand.top, cand.height);
    area_s1 <= AREA_W'(stored.width) * AREA_W'(stored.height);
  end

  // Stage 2: intersection area
  always_ff @(posedge clk) begin
    inter2  <= AREA_W'(ow1) * AREA_W'(oh1);
    area_s2 <= area_s1;
  end

  // Stage 3: union area
  always_ff @(posedge clk) begin
    uni3   <= UNION_W'(area_s2) + UNION_W'(cand_area) - UNION_W'(inter2);
    inter3 <= inter2;
  end

  // Stage 4: scaled compare, a zero union never suppresses
  assign prod     = PROD_W'(thr) * PROD_W'(uni3);
  assign inter_sh = PROD_W'({inter3, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      hit4 <= 1'b0;
    end else begin
      hit4 <= v3 && (uni3 != '0) && !(inter_sh < prod);
    end
  end

  assign status.busy = v0 | v1 | v2 | v3 | v4;
  assign status.hit  = v4 & hit4;

endmodule

// File: design/gbs_back.sv
// Back end: walks the accepted store for each queued candidate, decides,
// appends kept boxes and holds the result. Depends on gbs_pkg, gbs_ram, gbs_iou.
`timescale 1ns / 1ps

module gbs_back #(
  parameter int MAX_ACCEPTED = gbs_pkg::MAX_ACCEPTED_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gbs_pkg::THR_W-1:0]   thr,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  gbs_pkg::item_t              q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic                        store_full,
  output logic [gbs_pkg::TOTAL_W-1:0] accepted_total
);
  import gbs_pkg::*;

  localparam int CW = $clog2(MAX_ACCEPTED + 1);
  localparam int AW = (MAX_ACCEPTED > 1) ? $clog2(MAX_ACCEPTED) : 1;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ACCEPTED);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t      state, state_next;
  item_t       cand;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic        sup;
  logic        rd_issue;
  logic        wr_en;
  logic        commit;
  logic        room;
  logic [BOX_W-1:0] rd_data;
  box_t        stored;
  iou_status_t status;

  assign room     = (count != COUNT_MAX);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign rd_issue = (state == ST_SCAN) && (idx != count);
  assign commit   = (state == ST_DONE) && (!out_valid || out_ready);
  assign wr_en    = commit && !sup && room;
  assign stored   = box_t'(rd_data);

  gbs_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_ACCEPTED)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (cand.box),
    .re    (rd_issue),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  gbs_iou u_iou (
    .clk       (clk),
    .rst       (rst),
    .rd_issue  (rd_issue),
    .stored    (stored),
    .cand      (cand.box),
    .cand_area (cand.area),
    .thr       (thr),
    .status    (status)
  );

  // Sequence one candidate: take, scan, drain, commit
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = ST_SCAN;
      ST_SCAN:  if (idx == count) state_next = ST_DRAIN;
      ST_DRAIN: if (!status.busy) state_next = ST_DONE;
      ST_DONE:  if (commit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
      sup   <= 1'b0;
    end else begin
      state <= state_next;
      // Take a candidate, empty the store on a new set
      if (q_pop) begin
        idx <= '0;
        sup <= 1'b0;
        if (q_item.first_of_set) begin
          count <= '0;
        end
      end else begin
        if (rd_issue) begin
          idx <= idx + CW'(1);
        end
        if (status.hit) begin
          sup <= 1'b1;
        end
        if (wr_en) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  // Hold the candidate while it is worked on
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cand <= q_item;
    end
  end

  // Output register: load on commit, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      accepted       <= !sup;
      store_full     <= !sup && !room;
      accepted_total <= wr_en ? TOTAL_W'(count + CW'(1)) : TOTAL_W'(count);
    end
  end

endmodule

// File: design/greedy_box_suppression.sv
// Greedy IoU box suppression, top level: threshold register, intake queue
// and store-walking back end. Depends on gbs_pkg, gbs_front, gbs_back.
//
//   channel  | signals                                          | dir
//   ---------+--------------------------------------------------+-----
//   in       | in_valid/in_ready, first_of_set, box_left,       | in
//            | box_top, box_width, box_height                   |
//   out      | out_valid/out_ready, accepted, store_full,       | out
//            | accepted_total                                   |
//   cfg      | cfg_we, cfg_wdata (iou_threshold)                | in
//
// The back end checks each candidate against all N boxes in the store (N up to
// MAX_ACCEPTED): the single store read port feeds one stored box per cycle
// into the registered read plus a four-stage overlap pipeline, which drains
// before the verdict is committed. A two-entry queue lets new candidates
// transfer while the back end works or while a result waits on out_ready.
// Reset (rst, synchronous) empties the queue and the store and sets the
// threshold to 128; no clearing pass.
`timescale 1ns / 1ps

module greedy_box_suppression #(
  parameter int MAX_ACCEPTED = gbs_pkg::MAX_ACCEPTED_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gbs_pkg::THR_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        first_of_set,
  input  logic [gbs_pkg::COORD_W-1:0] box_left,
  input  logic [gbs_pkg::COORD_W-1:0] box_top,
  input  logic [gbs_pkg::COORD_W-1:0] box_width,
  input  logic [gbs_pkg::COORD_W-1:0] box_height,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic                        store_full,
  output logic [gbs_pkg::TOTAL_W-1:0] accepted_total
);
  import gbs_pkg::*;

  logic [THR_W-1:0] iou_threshold;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= THR_RESET;
    end else if (cfg_we) begin
      iou_threshold <= cfg_wdata;
    end
  end

  gbs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_of_set (first_of_set),
    .box_left     (box_left),
    .box_top      (box_top),
    .box_width    (box_width),
    .box_height   (box_height),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item)
  );

  gbs_back #(
    .MAX_ACCEPTED (MAX_ACCEPTED)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .thr            (iou_threshold),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .store_full     (store_full),
    .accepted_total (accepted_total)
  );

endmodule

// File: dv/greedy_box_suppression_tb.sv
// Self-checking testbench for greedy_box_suppression: predicts each verdict from
// a local model of the suppression store and checks every result transfer.
// Depends on gbs_pkg and the greedy_box_suppression RTL.
`timescale 1ns / 1ps

module greedy_box_suppression_tb;
  import gbs_pkg::*;

  localparam int KEEP_DEPTH      = MAX_ACCEPTED_DEF;
  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  localparam int IDLE_PCT        = 21;
  localparam int CALM_FROM       = 900;
  localparam int CALM_TO         = 1150;
  localparam int HOLD_AT         = 470;
  localparam int HOLD_LEN        = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 200;
  localparam int PHASE_ITEMS     = 180;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_PRINTED     = 200;

  typedef enum logic [1:0] {ACT_BOX, ACT_THR, ACT_DRAIN} act_t;
  typedef enum logic [1:0] {SHAPE_CLUSTER, SHAPE_SPREAD, SHAPE_NOISE} shape_t;

  typedef struct {
    act_t             act;
    logic             first;
    box_t             box;
    logic [THR_W-1:0] thr;
  } stim_t;

  typedef struct packed {
    logic               accepted;
    logic               store_full;
    logic [TOTAL_W-1:0] total;
  } verdict_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_we         = 1'b0;
  logic [THR_W-1:0]    cfg_wdata      = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                first_of_set   = 1'b0;
  logic [COORD_W-1:0]  box_left       = '0;
  logic [COORD_W-1:0]  box_top        = '0;
  logic [COORD_W-1:0]  box_width      = '0;
  logic [COORD_W-1:0]  box_height     = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic                accepted;
  logic                store_full;
  logic [TOTAL_W-1:0]  accepted_total;

  // Model state: kept boxes of the current set and the threshold register
  box_t                kept_boxes [KEEP_DEPTH];
  int unsigned         kept_count     = 0;
  logic [THR_W-1:0]    thr_model      = THR_RESET;

  stim_t               stim_q [$];
  verdict_t            verdict_q [$];
  logic                box_taken      = 1'b0;
  int                  boxes_sent     = 0;
  int                  results_seen   = 0;
  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;
  int                  cycle_count    = 0;
  int                  hold_left      = 0;
  logic                hold_done      = 1'b0;
  logic                calm;

  assign calm = (boxes_sent >= CALM_FROM) && (boxes_sent < CALM_TO);

  greedy_box_suppression dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_of_set   (first_of_set),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_width      (box_width),
    .box_height     (box_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .store_full     (store_full),
    .accepted_total (accepted_total)
  );

  always #5 clk = ~clk;

  // Overlap length of two half-open spans
  function automatic logic [63:0] run_overlap(logic [COORD_W-1:0] a0, logic [COORD_W-1:0] alen,
                                              logic [COORD_W-1:0] b0, logic [COORD_W-1:0] blen);
    logic [63:0] lo;
    logic [63:0] a_end;
    logic [63:0] b_end;
    logic [63:0] hi;
    lo    = (a0 > b0) ? 64'(a0) : 64'(b0);
    a_end = 64'(a0) + 64'(alen);
    b_end = 64'(b0) + 64'(blen);
    hi    = (a_end < b_end) ? a_end : b_end;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // True when the stored box suppresses the candidate; zero union never does
  function automatic bit too_close(box_t kept, box_t cand);
    logic [63:0] inter;
    logic [63:0] area_kept;
    logic [63:0] area_cand;
    logic [63:0] uni;
    inter     = run_overlap(kept.left, kept.width, cand.left, cand.width) *
                run_overlap(kept.top, kept.height, cand.top, cand.height);
    area_kept = 64'(kept.width) * 64'(kept.height);
    area_cand = 64'(cand.width) * 64'(cand.height);
    uni       = area_kept + area_cand - inter;
    if (uni == 64'd0) return 1'b0;
    return !(inter * 64'd256 < 64'(thr_model) * uni);
  endfunction

  // Advance the model by one candidate and return its verdict
  function automatic verdict_t judge_box(logic first, box_t cand);
    verdict_t    v;
    bit          keep;
    int unsigned i;
    if (first) kept_count = 0;
    keep = 1'b1;
    for (i = 0; i < kept_count && keep; i++) begin
      keep = !too_close(kept_boxes[i], cand);
    end
    v.accepted   = keep;
    v.store_full = 1'b0;
    if (keep) begin
      if (kept_count < KEEP_DEPTH) begin
        kept_boxes[kept_count] = cand;
        kept_count++;
      end else begin
        v.store_full = 1'b1;
      end
    end
    v.total = kept_count[TOTAL_W-1:0];
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] clip_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return v[COORD_W-1:0];
  endfunction

  // Build one random candidate of the given shape
  function automatic box_t make_box(shape_t shape, int cx, int cy, int bw, int bh);
    box_t b;
    int   w;
    int   h;
    int   r;
    case (shape)
      SHAPE_CLUSTER: begin
        w        = bw + int'($urandom_range(bw / 4)) - bw / 8;
        h        = bh + int'($urandom_range(bh / 4)) - bh / 8;
        b.width  = clip_coord(w);
        b.height = clip_coord(h);
        b.left   = clip_coord(cx - w / 2 + int'($urandom_range(bw / 4)) - bw / 8);
        b.top    = clip_coord(cy - h / 2 + int'($urandom_range(bh / 4)) - bh / 8);
      end
      SHAPE_SPREAD: begin
        b.left   = COORD_W'($urandom_range(COORD_MAX));
        b.top    = COORD_W'($urandom_range(COORD_MAX));
        b.width  = COORD_W'($urandom_range(40, 1));
        b.height = COORD_W'($urandom_range(40, 1));
      end
      default: begin
        b = BOX_W'({$urandom, $urandom});
      end
    endcase
    // Drop in some flat boxes
    r = $urandom_range(99);
    if (r < 4) b.width = '0;
    else if (r < 8) b.height = '0;
    else if (r < 10) begin
      b.width  = '0;
      b.height = '0;
    end
    return b;
  endfunction

  // Append one entry to the stimulus queue
  task automatic enqueue_stim(stim_t s);
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic add_box(logic first, box_t b);
    enqueue_stim('{act: ACT_BOX, first: first, box: b, thr: '0});
  endtask

  task automatic add_thr(logic [THR_W-1:0] thr);
    enqueue_stim('{act: ACT_THR, first: 1'b0, box: '0, thr: thr});
  endtask

  task automatic add_drain();
    enqueue_stim('{act: ACT_DRAIN, first: 1'b0, box: '0, thr: '0});
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch on result %0d: %s got %0d, want %0d", results_seen, what, got, want);
  endtask

  // Sender: hold until transfer, then offer the next box, perform a queued write or wait out a drain
  always @(negedge clk) begin : feed_boxes
    logic             v_nxt;
    logic             f_nxt;
    box_t             b_nxt;
    logic             we_nxt;
    logic [THR_W-1:0] wd_nxt;
    stim_t            head;
    v_nxt  = in_valid;
    f_nxt  = first_of_set;
    b_nxt  = {box_left, box_top, box_width, box_height};
    we_nxt = 1'b0;
    wd_nxt = cfg_wdata;
    if (verdict_q.size() == 0 && !in_valid) quiet_cycles++;
    else quiet_cycles = 0;
    if (!rst && !(in_valid && !box_taken)) begin
      v_nxt = 1'b0;
      if (stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.act)
          ACT_BOX: begin
            if (calm || $urandom_range(99) >= IDLE_PCT) begin
              v_nxt = 1'b1;
              f_nxt = head.first;
              b_nxt = head.box;
              void'(stim_q.pop_front());
            end
          end
          ACT_THR: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              we_nxt = 1'b1;
              wd_nxt = head.thr;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            if (quiet_cycles != 0) void'(stim_q.pop_front());
          end
        endcase
      end
    end
    in_valid     <= v_nxt;
    first_of_set <= f_nxt;
    box_left     <= b_nxt.left;
    box_top      <= b_nxt.top;
    box_width    <= b_nxt.width;
    box_height   <= b_nxt.height;
    cfg_we       <= we_nxt;
    cfg_wdata    <= wd_nxt;
  end

  // Receiver: random stalls, one long hold-off to back the block up
  always @(negedge clk) begin : take_results
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && boxes_sent >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: track register writes, check results, predict accepted boxes
  always @(posedge clk) begin : watch_ports
    verdict_t want;
    box_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_we) thr_model = cfg_wdata;
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with none pending, accepted_total", accepted_total, 0);
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.accepted)
            report_mismatch("accepted", accepted, want.accepted);
          if (store_full !== want.store_full)
            report_mismatch("store_full", store_full, want.store_full);
          if (accepted_total !== want.total)
            report_mismatch("accepted_total", accepted_total, want.total);
        end
      end
      if (in_valid && in_ready) begin
        verdict_q.insert(verdict_q.size(),
                         judge_box(first_of_set, {box_left, box_top, box_width, box_height}));
        boxes_sent++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run_test
    logic [THR_W-1:0] thr_plan [8];
    int               cx [4];
    int               cy [4];
    int               bw [4];
    int               bh [4];
    int               ph;
    int               made;
    int               set_len;
    int               groups;
    int               n;
    int               k;
    shape_t           shape;
    logic             first;

    // Directed: empty store, flat boxes, extreme corners, touching and nested boxes
    add_box(1'b0, {12'd0, 12'd0, 12'd0, 12'd0});
    add_box(1'b0, {12'd5, 12'd5, 12'd0, 12'd0});
    add_box(1'b1, {12'd0, 12'd0, 12'd4095, 12'd4095});
    add_box(1'b0, {12'd4095, 12'd4095, 12'd4095, 12'd4095});
    add_box(1'b0, {12'd0, 12'd0, 12'd4095, 12'd4095});
    add_box(1'b0, {12'd100, 12'd100, 12'd200, 12'd200});
    add_box(1'b0, {12'd110, 12'd100, 12'd200, 12'd200});
    add_box(1'b0, {12'd300, 12'd100, 12'd200, 12'd200});
    add_box(1'b0, {12'd4095, 12'd0, 12'd4095, 12'd0});
    // Zero threshold: only an empty store or a zero union lets a box through
    add_thr(9'd0);
    add_box(1'b1, {12'd10, 12'd10, 12'd10, 12'd10});
    add_box(1'b0, {12'd2000, 12'd2000, 12'd10, 12'd10});
    add_box(1'b0, {12'd0, 12'd0, 12'd0, 12'd0});
    add_box(1'b1, {12'd1, 12'd1, 12'd0, 12'd5});
    add_box(1'b0, {12'd9, 12'd9, 12'd7, 12'd0});
    // Full-scale threshold: identical boxes sit exactly on the limit
    add_thr(9'd256);
    add_box(1'b1, {12'd0, 12'd0, 12'd16, 12'd16});
    add_box(1'b0, {12'd0, 12'd0, 12'd16, 12'd16});
    add_box(1'b0, {12'd0, 12'd0, 12'd16, 12'd15});
    // Above full scale: nothing is suppressed
    add_thr(9'd511);
    add_box(1'b1, {12'd0, 12'd0, 12'd16, 12'd16});
    add_box(1'b0, {12'd0, 12'd0, 12'd16, 12'd16});
    add_box(1'b0, {12'd0, 12'd0, 12'd16, 12'd16});

    // Random phases, one threshold each; sets of clustered, spread or raw boxes
    thr_plan    = '{9'd0, 9'd256, 9'd511, 9'd64, 9'd300, 9'd0, 9'd0, 9'd128};
    thr_plan[5] = THR_W'($urandom_range(255, 1));
    thr_plan[6] = THR_W'($urandom_range(511, 257));
    for (ph = 0; ph < 8; ph++) begin
      add_thr(thr_plan[ph]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        k       = $urandom_range(99);
        shape   = (k < 55) ? SHAPE_CLUSTER : (k < 85) ? SHAPE_SPREAD : SHAPE_NOISE;
        set_len = $urandom_range(30, 1);
        // Long sets overrun the store
        if ($urandom_range(99) < 15) begin
          set_len = $urandom_range(72, 66);
          shape   = SHAPE_SPREAD;
        end
        groups = $urandom_range(4, 1);
        for (k = 0; k < groups; k++) begin
          cx[k] = $urandom_range(COORD_MAX);
          cy[k] = $urandom_range(COORD_MAX);
          bw[k] = $urandom_range(600, 8);
          bh[k] = $urandom_range(600, 8);
        end
        for (n = 0; n < set_len; n++) begin
          first = (n == 0) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 2);
          k     = $urandom_range(groups - 1);
          add_box(first, make_box(shape, cx[k], cy[k], bw[k], bh[k]));
        end
        made += set_len;
        if ($urandom_range(99) < 8) add_drain();
      end
    end

    // Release reset on a falling clock edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Drain everything, then let the pipeline settle
    while (stim_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
